/* sv/q8gsd_pkg.sv */
// shared types, constants and float helpers for the q8 group scaled dot product unit
// no dependencies; used by q8gsd_fma_unit and the top level
`timescale 1ns / 1ps

package q8gsd_pkg;

    localparam int GROUP_K_DEF    = 32;
    localparam int MAX_GROUPS_DEF = 1024;
    localparam int CFG_W          = 11;
    localparam int FP_W           = 32;
    localparam int MAG_W          = 24;
    // alignment window: beyond this exponent gap the smaller operand is only sticky
    localparam int ALIGN_D        = 80;
    localparam int ACC_W          = 2 * MAG_W + ALIGN_D + 2;
    localparam int SH_W           = $clog2(ALIGN_D + 1);
    localparam int EXP_W          = 12;
    localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
    // register index of groups_in_row
    localparam logic REG_GROUPS_IN_ROW = 1'b0;

    typedef logic signed [EXP_W-1:0] t_exp;

    // unpacked operand: value = m * 2^e
    typedef struct packed {
        logic             s;
        logic [MAG_W-1:0] m;
        t_exp             e;
        logic             inf;
        logic             nan;
        logic             zero;
    } t_fp_unp;

    // request to the shared unit: round(a * b + c)
    typedef struct packed {
        logic [FP_W-1:0] a;
        t_fp_unp         b;
        logic [FP_W-1:0] c;
    } t_fma_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

    function automatic t_fp_unp fp_unpack(input logic [FP_W-1:0] x);
        t_fp_unp u;
        u.s    = x[31];
        u.m    = {|x[30:23], x[22:0]};
        u.e    = (x[30:23] == 8'd0) ? t_exp'(-149)
                                    : t_exp'({4'b0000, x[30:23]}) - t_exp'(150);
        u.inf  = (&x[30:23]) & ~(|x[22:0]);
        u.nan  = (&x[30:23]) & (|x[22:0]);
        u.zero = ~(|x[30:0]);
        return u;
    endfunction

endpackage

/* sv/q8gsd_fma_unit.sv */
// shared binary32 multiply-add unit, result = round(a * b + c) with one rounding
// depends on q8gsd_pkg; one step of a small sequencer per cycle
`timescale 1ns / 1ps

module q8gsd_fma_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  q8gsd_pkg::t_fma_req        i_req,
    output q8gsd_pkg::t_unit_stat      o_stat,
    output logic [q8gsd_pkg::FP_W-1:0] o_result
);

    localparam int AW = q8gsd_pkg::ACC_W;
    localparam int MW = q8gsd_pkg::MAG_W;

    typedef enum logic [5:0] {
        U_IDLE   = 6'b000001,
        U_MUL    = 6'b000010,
        U_ALIGN  = 6'b000100,
        U_NORM   = 6'b001000,
        U_DENORM = 6'b010000,
        U_ROUND  = 6'b100000
    } t_ustate;

    t_ustate               r_state;
    logic                  r_done;
    logic [31:0]           r_res;
    q8gsd_pkg::t_fp_unp    r_a, r_b, r_c;
    logic [2*MW-1:0]       r_mp;
    q8gsd_pkg::t_exp       r_ep;
    logic                  r_sp;
    logic                  r_pz;
    logic [AW-1:0]         r_n;
    logic                  r_sign;
    q8gsd_pkg::t_exp       r_be;

    // special operand handling
    logic sp, p_inf, p_zero, is_nan;
    always_comb begin
        sp     = r_a.s ^ r_b.s;
        p_inf  = r_a.inf | r_b.inf;
        p_zero = r_a.zero | r_b.zero;
        is_nan = r_a.nan | r_b.nan | r_c.nan | (r_a.inf & r_b.zero) | (r_b.inf & r_a.zero)
                 | (p_inf & r_c.inf & (sp != r_c.s));
    end

    // alignment and exact signed add
    logic                  big_is_p, small_zero, clamp, sbig, ssmall;
    q8gsd_pkg::t_exp       ebig, esmall, gap, eres, be0;
    logic [2*MW-1:0]       mbig, msmall, ms;
    logic [q8gsd_pkg::SH_W-1:0] dd;
    logic [AW-1:0]         big_sh, sum_same, sum_diff, mag;
    logic                  sum_sign;
    always_comb begin
        big_is_p   = r_c.zero | (~r_pz & (r_ep >= r_c.e));
        ebig       = big_is_p ? r_ep : r_c.e;
        esmall     = big_is_p ? r_c.e : r_ep;
        mbig       = big_is_p ? r_mp : (2*MW)'(r_c.m);
        msmall     = big_is_p ? (2*MW)'(r_c.m) : r_mp;
        sbig       = big_is_p ? r_sp : r_c.s;
        ssmall     = big_is_p ? r_c.s : r_sp;
        small_zero = big_is_p ? r_c.zero : r_pz;
        gap        = ebig - esmall;
        clamp      = ~small_zero & (gap > q8gsd_pkg::t_exp'(q8gsd_pkg::ALIGN_D));
        if (small_zero) begin
            dd = '0;
        end else if (clamp) begin
            dd = q8gsd_pkg::SH_W'(q8gsd_pkg::ALIGN_D);
        end else begin
            dd = gap[q8gsd_pkg::SH_W-1:0];
        end
        ms       = clamp ? (2*MW)'(1) : msmall;
        big_sh   = AW'(mbig) << dd;
        sum_same = big_sh + AW'(ms);
        sum_diff = big_sh - AW'(ms);
        if (sbig == ssmall) begin
            mag      = sum_same;
            sum_sign = sbig;
        end else if (sum_diff[AW-1]) begin
            mag      = -sum_diff;
            sum_sign = ssmall;
        end else begin
            mag      = sum_diff;
            sum_sign = sbig;
        end
        eres = ebig - q8gsd_pkg::t_exp'(dd);
        be0  = eres + q8gsd_pkg::t_exp'(AW - 1 + 127);
    end

    // round to nearest even at the binary32 boundary
    logic [MW-1:0]   rm;
    logic            rg, rst, rinc;
    logic [MW:0]     rm1;
    logic [MW-1:0]   rmant;
    q8gsd_pkg::t_exp rbe;
    logic [31:0]     rword;
    always_comb begin
        rm    = r_n[AW-1 -: MW];
        rg    = r_n[AW-1-MW];
        rst   = |r_n[AW-2-MW:0];
        rinc  = rg & (rst | rm[0]);
        rm1   = {1'b0, rm} + (MW+1)'(rinc);
        rmant = rm1[MW] ? rm1[MW:1] : rm1[MW-1:0];
        rbe   = rm1[MW] ? r_be + q8gsd_pkg::t_exp'(1) : r_be;
        if (rbe >= q8gsd_pkg::t_exp'(255)) begin
            rword = {r_sign, 8'hFF, 23'd0};
        end else begin
            rword = {r_sign, rmant[MW-1] ? rbe[7:0] : 8'd0, rmant[MW-2:0]};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    if (is_nan || p_inf || r_c.inf || (p_zero && r_c.zero)) begin
                        r_state <= U_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= U_ALIGN;
                    end
                end
                U_ALIGN: begin
                    if (mag == '0) begin
                        r_state <= U_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_state <= U_NORM;
                    end
                end
                U_NORM: begin
                    if (r_n[AW-1]) begin
                        r_state <= U_DENORM;
                    end
                end
                U_DENORM: begin
                    if (r_be >= q8gsd_pkg::t_exp'(1)) begin
                        r_state <= U_ROUND;
                    end
                end
                U_ROUND: begin
                    r_state <= U_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                if (i_start) begin
                    r_a <= q8gsd_pkg::fp_unpack(i_req.a);
                    r_b <= i_req.b;
                    r_c <= q8gsd_pkg::fp_unpack(i_req.c);
                end
            end
            U_MUL: begin
                r_mp <= r_a.m * r_b.m;
                r_ep <= r_a.e + r_b.e;
                r_sp <= sp;
                r_pz <= p_zero;
                if (is_nan) begin
                    r_res <= q8gsd_pkg::CANON_NAN;
                end else if (p_inf || r_c.inf) begin
                    r_res <= {p_inf ? sp : r_c.s, 8'hFF, 23'd0};
                end else begin
                    r_res <= {sp & r_c.s, 31'd0};
                end
            end
            U_ALIGN: begin
                r_n    <= mag;
                r_sign <= sum_sign;
                r_be   <= be0;
                r_res  <= '0;
            end
            U_NORM: begin
                if (r_n[AW-1 -: 8] == 8'd0) begin
                    r_n  <= r_n << 8;
                    r_be <= r_be - q8gsd_pkg::t_exp'(8);
                end else if (!r_n[AW-1]) begin
                    r_n  <= r_n << 1;
                    r_be <= r_be - q8gsd_pkg::t_exp'(1);
                end
            end
            U_DENORM: begin
                if (r_be <= q8gsd_pkg::t_exp'(-7)) begin
                    r_n  <= {8'd0, r_n[AW-1:9], r_n[8] | (|r_n[7:0])};
                    r_be <= r_be + q8gsd_pkg::t_exp'(8);
                end else if (r_be < q8gsd_pkg::t_exp'(1)) begin
                    r_n  <= {1'b0, r_n[AW-1:2], r_n[1] | r_n[0]};
                    r_be <= r_be + q8gsd_pkg::t_exp'(1);
                end
            end
            U_ROUND: begin
                r_res <= rword;
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_stat.busy = (r_state != U_IDLE);
    assign o_stat.done = r_done;
    assign o_result    = r_res;

endmodule

/* sv/q8_group_scaled_dot_product_unit.sv */
// a non-final item of a group is summed as it is taken; the last item of a group holds
// the input while the shared multiply-add runs (one- and eight-bit normalising steps);
// the last item of a row also waits for the weight scaling and the load of the output register
// throughput: one item per cycle in a group; stalls for the shared unit and the output load
// reset: synchronous active low, clears sums, counters, accumulator and groups_in_row = 1
// top level; depends on q8gsd_pkg and q8gsd_fma_unit
`timescale 1ns / 1ps

module q8_group_scaled_dot_product_unit #(
    parameter int GROUP_K    = q8gsd_pkg::GROUP_K_DEF,
    parameter int MAX_GROUPS = q8gsd_pkg::MAX_GROUPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // act_0..act_3 [31:0], wgt_0..wgt_3 [63:32], group_act_scale [95:64],
    // lane_weight_scale [127:96]
    input  logic [127:0] s_axis_tdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // dot_result [31:0]
    output logic [31:0]  m_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int SUM_W = $clog2(GROUP_K) + 16;
    localparam int ITEMS = GROUP_K / 4;
    localparam int IW    = (ITEMS > 1) ? $clog2(ITEMS) : 1;
    localparam int GW    = $clog2(MAX_GROUPS + 1);
    localparam int CW    = ((GW > q8gsd_pkg::CFG_W) ? GW : q8gsd_pkg::CFG_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FMA  = 4'b0010,
        S_MUL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [q8gsd_pkg::CFG_W-1:0]   r_cfg;
    logic signed [SUM_W-1:0]       r_sum;
    logic [IW-1:0]                 r_item;
    logic [GW-1:0]                 r_gcnt;
    logic [31:0]                   r_acc;
    logic [31:0]                   r_wscale;
    logic                          r_row_end;
    logic [31:0]                   r_hold;
    logic                          r_out_valid;
    logic [31:0]                   r_out_data;

    q8gsd_pkg::t_fma_req   unit_req;
    q8gsd_pkg::t_unit_stat unit_stat;
    logic [31:0]           unit_res;
    logic                  unit_start;

    // configuration port
    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == q8gsd_pkg::REG_GROUPS_IN_ROW);
    assign pready = 1'b1;
    assign prdata = (paddr[2] == q8gsd_pkg::REG_GROUPS_IN_ROW)
                    ? {{(32 - q8gsd_pkg::CFG_W){1'b0}}, r_cfg} : 32'd0;

    // effective group target, zero taken as one and clamped to the maximum
    logic [CW-1:0] tgt, gnext;
    always_comb begin
        if (r_cfg == '0) begin
            tgt = CW'(1);
        end else if (CW'(r_cfg) > CW'(MAX_GROUPS)) begin
            tgt = CW'(MAX_GROUPS);
        end else begin
            tgt = CW'(r_cfg);
        end
        gnext = CW'(r_gcnt) + CW'(1);
    end

    // four exact int8 products of the incoming transaction
    logic signed [15:0]      prod [4];
    logic signed [SUM_W-1:0] dot, n_sum;
    logic [SUM_W-1:0]        n_mag;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            prod[i] = $signed(s_axis_tdata[8*i +: 8]) * $signed(s_axis_tdata[32 + 8*i +: 8]);
        end
        dot   = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + SUM_W'(prod[3]);
        n_sum = r_sum + dot;
        n_mag = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    end

    logic in_acc, last_item;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign last_item     = (r_item == IW'(ITEMS - 1));

    // request to the shared unit: group fma or final weight scaling
    always_comb begin
        unit_start = 1'b0;
        if (r_state == S_IDLE) begin
            unit_req.a      = s_axis_tdata[95:64];
            unit_req.b.s    = n_sum[SUM_W-1];
            unit_req.b.m    = q8gsd_pkg::MAG_W'(n_mag);
            unit_req.b.e    = '0;
            unit_req.b.inf  = 1'b0;
            unit_req.b.nan  = 1'b0;
            unit_req.b.zero = (n_sum == '0);
            unit_req.c      = r_acc;
            unit_start      = in_acc & last_item;
        end else begin
            unit_req.a = r_wscale;
            unit_req.b = q8gsd_pkg::fp_unpack(unit_res);
            unit_req.c = {r_wscale[31] ^ unit_res[31], 31'd0};
            unit_start = (r_state == S_FMA) & unit_stat.done & r_row_end;
        end
    end

    q8gsd_fma_unit u_fma (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (unit_start),
        .i_req    (unit_req),
        .o_stat   (unit_stat),
        .o_result (unit_res)
    );

    // item, group and row sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= q8gsd_pkg::CFG_W'(1);
            r_sum       <= '0;
            r_item      <= '0;
            r_gcnt      <= '0;
            r_acc       <= '0;
            r_row_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_cfg <= pwdata[q8gsd_pkg::CFG_W-1:0];
            end
            if (r_out_valid && m_axis_tready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (last_item) begin
                            r_sum     <= '0;
                            r_item    <= '0;
                            r_row_end <= (gnext >= tgt);
                            r_state   <= S_FMA;
                        end else begin
                            r_sum  <= n_sum;
                            r_item <= r_item + IW'(1);
                        end
                    end
                end
                S_FMA: begin
                    if (unit_stat.done) begin
                        if (r_row_end) begin
                            r_acc   <= '0;
                            r_gcnt  <= '0;
                            r_state <= S_MUL;
                        end else begin
                            r_acc   <= unit_res;
                            r_gcnt  <= gnext[GW-1:0];
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MUL: begin
                    if (unit_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc && last_item) begin
            r_wscale <= s_axis_tdata[127:96];
        end
        if (r_state == S_MUL && unit_stat.done) begin
            r_hold <= unit_res;
        end
        if (r_state == S_OUT && (!r_out_valid || m_axis_tready)) begin
            r_out_data <= r_hold;
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_stat.done |-> (r_state == S_FMA || r_state == S_MUL))
        else $error("shared unit finished with no operation outstanding");

    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !unit_stat.busy)
        else $error("input ready while the shared unit is busy");

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        unit_start |-> !unit_stat.busy)
        else $error("shared unit started while busy");

    a_item_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item <= IW'(ITEMS - 1))
        else $error("item counter past end of group");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_valid) |=> r_out_valid)
        else $error("free output register not loaded");
`endif

endmodule
